/* sv/mts_pkg.sv */
package mts_pkg;

  localparam int MaxCommentDepth = 15;
  localparam logic [7:0] MaxLexeme = 8'd255;
  localparam int NumWords = 8;

  // result queue between the scanner and the output stage
  localparam int QueueDepth = 4;
  localparam int QIdxW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  // token kinds
  localparam logic [3:0] KindIdent        = 4'd0;
  localparam logic [3:0] KindString       = 4'd1;
  localparam logic [3:0] KindEnd          = 4'd2;
  localparam logic [3:0] KindUnknown      = 4'd3;
  localparam logic [3:0] KindReservedBase = 4'd4;
  localparam logic [3:0] KindComma        = 4'd12;
  localparam logic [3:0] KindHash         = 4'd13;
  localparam logic [3:0] KindError        = 4'd14;

  // error codes
  localparam logic [2:0] ErrNone            = 3'd0;
  localparam logic [2:0] ErrEndInBlock      = 3'd1;
  localparam logic [2:0] ErrLineEndInString = 3'd2;
  localparam logic [2:0] ErrEndInString     = 3'd3;
  localparam logic [2:0] ErrTooDeep         = 3'd4;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  err;
    logic [15:0] line;
    logic [7:0]  col;
    logic [7:0]  len;
    logic        last;
  } res_t;

  // one queue entry: the one or two results caused by a single character
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } pair_t;

  function automatic logic [4:0] rw_len(input logic [2:0] w);
    logic [4:0] l;
    unique case (w)
      3'd0: l = 5'd7;
      3'd1: l = 5'd3;
      3'd2: l = 5'd4;
      3'd3: l = 5'd16;
      3'd4: l = 5'd5;
      3'd5: l = 5'd3;
      3'd6: l = 5'd6;
      3'd7: l = 5'd6;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

  function automatic logic [127:0] rw_text(input logic [2:0] w);
    logic [127:0] t;
    unique case (w)
      3'd0: t = 128'("PROGRAM");
      3'd1: t = 128'("END");
      3'd2: t = 128'("ENDL");
      3'd3: t = 128'(".--. .-. .. -. -");
      3'd4: t = 128'("-...-");
      3'd5: t = 128'("-.-");
      3'd6: t = 128'(".-.-.-");
      3'd7: t = 128'(".-..-.");
      default: t = '0;
    endcase
    return t;
  endfunction

  // character at position pos of reserved word w; caller checks pos < rw_len(w)
  function automatic logic [7:0] rw_char(input logic [2:0] w, input logic [3:0] pos);
    logic [127:0] t;
    logic [4:0]   off;
    t   = rw_text(w);
    off = rw_len(w) - 5'd1 - {1'b0, pos};
    return t[{off[3:0], 3'b000} +: 8];
  endfunction

endpackage

/* sv/mts_if.sv */
interface mts_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  ch;
  logic        is_line_end;
  logic        is_program_end;
  logic [15:0] line_number;
  logic [7:0]  line_column;

  modport source (
    output valid, ch, is_line_end, is_program_end, line_number, line_column,
    input  ready
  );
  modport sink (
    input  valid, ch, is_line_end, is_program_end, line_number, line_column,
    output ready
  );
endinterface

interface mts_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [2:0]  error_code;
  logic [15:0] start_line;
  logic [7:0]  start_column;
  logic [7:0]  lexeme_length;
  logic        last;

  modport source (
    output valid, token_kind, error_code, start_line, start_column, lexeme_length, last,
    input  ready
  );
  modport sink (
    input  valid, token_kind, error_code, start_line, start_column, lexeme_length, last,
    output ready
  );
endinterface

/* sv/mts_scan.sv */
module mts_scan #(
  parameter int MAX_COMMENT_DEPTH = mts_pkg::MaxCommentDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mts_in_if.sink        char_i,
  input  logic          full_i,
  output logic          push_o,
  output mts_pkg::pair_t pair_o
);
  import mts_pkg::*;

  localparam int DepthW = (MAX_COMMENT_DEPTH < 2) ? 1 : $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_COMMENT_DEPTH);

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeLinecom = 3'd1;
  localparam logic [2:0] ModeBlock   = 3'd2;
  localparam logic [2:0] ModeWord    = 3'd3;
  localparam logic [2:0] ModeStr     = 3'd4;
  localparam logic [2:0] ModeStresc  = 3'd5;
  localparam logic [2:0] ModeHalt    = 3'd6;

  localparam logic [1:0] HalfNone = 2'd0;
  localparam logic [1:0] HalfLt   = 2'd1;
  localparam logic [1:0] HalfGt   = 2'd2;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChBlank = 8'h20;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_run(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == ChUnder ||
           c == ChBlank || c == ChDash || c == ChDot;
  endfunction

  function automatic res_t mk_res(input logic [3:0] kind, input logic [2:0] err,
                                  input logic [15:0] line, input logic [7:0] col,
                                  input logic [7:0] len);
    res_t r;
    r.kind = kind;
    r.err  = err;
    r.line = line;
    r.col  = col;
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

  logic [2:0]        mode_q, mode_d;
  logic [DepthW-1:0] depth_q, depth_d, depth_dec;
  logic [1:0]        half_q, half_d;
  logic [NumWords-1:0] match_q, match_d, match_cont, match_start;
  logic [7:0]        tlen_q, tlen_d, tlen_inc;
  logic [15:0]       sline_q, sline_d;
  logic [7:0]        scol_q, scol_d;

  logic        acc, pe, le, plain, start_word, do_idle, idle_emit, consumed;
  logic [7:0]  c, uc;
  logic [3:0]  word_kind;
  logic [1:0]  n;
  res_t        first, second, idle_res;

  assign acc   = char_i.valid && char_i.ready;
  assign c     = char_i.ch;
  assign pe    = char_i.is_program_end;
  assign le    = !pe && char_i.is_line_end;
  assign plain = !le && !pe;
  assign uc    = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
  assign start_word = is_letter(c) || c == ChDash || c == ChDot;
  assign tlen_inc   = (tlen_q < MaxLexeme) ? (tlen_q + 8'd1) : tlen_q;
  assign depth_dec  = (depth_q != '0) ? (depth_q - DepthW'(1)) : depth_q;

  // per-word match bits, one comparator per reserved word
  always_comb begin
    for (int w = 0; w < NumWords; w++) begin
      match_start[w] = (rw_char(3'(w), 4'd0) == uc);
      match_cont[w]  = match_q[w] && ({3'b000, rw_len(3'(w))} > tlen_q) &&
                       (rw_char(3'(w), tlen_q[3:0]) == uc);
    end
  end

  // lowest-numbered matching word wins
  always_comb begin
    word_kind = KindIdent;
    for (int w = NumWords - 1; w >= 0; w--) begin
      if (match_q[w] && tlen_q == {3'b000, rw_len(3'(w))}) begin
        word_kind = KindReservedBase + 4'(w);
      end
    end
  end

  always_comb begin
    mode_d   = mode_q;
    depth_d  = depth_q;
    half_d   = half_q;
    match_d  = match_q;
    tlen_d   = tlen_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    first    = '0;
    second   = '0;
    idle_res = '0;
    n        = 2'd0;
    do_idle  = 1'b0;
    idle_emit = 1'b0;
    consumed = 1'b0;

    unique case (mode_q)
      ModeIdle: begin
        if (half_q == HalfLt) begin
          half_d = HalfNone;
          if (plain && c == ChTilde) begin
            mode_d = ModeLinecom;
          end else if (plain && c == ChLt) begin
            mode_d  = ModeBlock;
            depth_d = DepthW'(1);
          end else begin
            // lone '<' becomes an unknown token
            first   = mk_res(KindUnknown, ErrNone, sline_q, scol_q, 8'd1);
            n       = 2'd1;
            do_idle = 1'b1;
          end
        end else begin
          do_idle = 1'b1;
        end
      end
      ModeLinecom: begin
        if (le) begin
          mode_d = ModeIdle;
        end else if (pe) begin
          mode_d  = ModeIdle;
          do_idle = 1'b1;
        end
      end
      ModeBlock: begin
        if (pe) begin
          first  = mk_res(KindError, ErrEndInBlock, char_i.line_number,
                          char_i.line_column, 8'd0);
          n      = 2'd1;
          mode_d = ModeHalt;
          half_d = HalfNone;
        end else begin
          if (half_q == HalfLt) begin
            half_d = HalfNone;
            if (!le && c == ChLt) begin
              consumed = 1'b1;
              if (depth_q >= DepthMax) begin
                first  = mk_res(KindError, ErrTooDeep, char_i.line_number,
                                char_i.line_column, 8'd0);
                n      = 2'd1;
                mode_d = ModeHalt;
              end else begin
                depth_d = depth_q + DepthW'(1);
              end
            end
          end else if (half_q == HalfGt) begin
            half_d = HalfNone;
            if (!le && c == ChGt) begin
              consumed = 1'b1;
              depth_d  = depth_dec;
              if (depth_dec == '0) mode_d = ModeIdle;
            end
          end
          if (!consumed && !le) begin
            if (c == ChLt) half_d = HalfLt;
            else if (c == ChGt) half_d = HalfGt;
          end
        end
      end
      ModeWord: begin
        if (plain && is_run(c)) begin
          match_d = match_cont;
          tlen_d  = tlen_inc;
        end else begin
          first   = mk_res(word_kind, ErrNone, sline_q, scol_q, tlen_q);
          n       = 2'd1;
          mode_d  = ModeIdle;
          do_idle = 1'b1;
        end
      end
      ModeStr: begin
        if (pe) begin
          first  = mk_res(KindError, ErrEndInString, sline_q, scol_q, 8'd0);
          n      = 2'd1;
          mode_d = ModeHalt;
          half_d = HalfNone;
        end else if (le) begin
          first  = mk_res(KindError, ErrLineEndInString, sline_q, scol_q, 8'd0);
          n      = 2'd1;
          mode_d = ModeHalt;
          half_d = HalfNone;
        end else if (c == ChQuote) begin
          first  = mk_res(KindString, ErrNone, sline_q, scol_q, tlen_q);
          n      = 2'd1;
          mode_d = ModeIdle;
        end else if (c == ChBslash) begin
          mode_d = ModeStresc;
        end else begin
          tlen_d = tlen_inc;
        end
      end
      ModeStresc: begin
        if (pe) begin
          first  = mk_res(KindError, ErrEndInString, sline_q, scol_q, 8'd0);
          n      = 2'd1;
          mode_d = ModeHalt;
          half_d = HalfNone;
        end else begin
          tlen_d = tlen_inc;
          mode_d = ModeStr;
        end
      end
      default: begin
        mode_d = ModeHalt;
      end
    endcase

    // scan of the current character from idle
    if (do_idle) begin
      if (pe) begin
        idle_res  = mk_res(KindEnd, ErrNone, char_i.line_number, char_i.line_column, 8'd0);
        idle_emit = 1'b1;
      end else if (!(le || c == ChSlash || c == ChTab)) begin
        sline_d = char_i.line_number;
        scol_d  = char_i.line_column;
        if (c == ChLt) begin
          half_d = HalfLt;
        end else if (start_word) begin
          mode_d  = ModeWord;
          tlen_d  = 8'd1;
          match_d = match_start;
        end else if (c == ChQuote) begin
          mode_d = ModeStr;
          tlen_d = 8'd0;
        end else begin
          idle_emit = 1'b1;
          if (c == ChComma) begin
            idle_res = mk_res(KindComma, ErrNone, char_i.line_number,
                              char_i.line_column, 8'd1);
          end else if (c == ChHash) begin
            idle_res = mk_res(KindHash, ErrNone, char_i.line_number,
                              char_i.line_column, 8'd1);
          end else begin
            idle_res = mk_res(KindUnknown, ErrNone, char_i.line_number,
                              char_i.line_column, 8'd1);
          end
        end
      end
    end

    if (idle_emit) begin
      if (n == 2'd0) first = idle_res;
      else second = idle_res;
      n = n + 2'd1;
    end

    first.last  = (n == 2'd1);
    second.last = 1'b1;
  end

  assign char_i.ready  = !full_i;
  assign push_o        = acc && (n != 2'd0);
  assign pair_o.two    = (n == 2'd2);
  assign pair_o.first  = first;
  assign pair_o.second = second;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      depth_q <= '0;
      half_q  <= HalfNone;
      match_q <= '1;
      tlen_q  <= '0;
      sline_q <= '0;
      scol_q  <= '0;
    end else if (acc) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      half_q  <= half_d;
      match_q <= match_d;
      tlen_q  <= tlen_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
    end
  end

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeHalt |=> mode_q == ModeHalt)
    else $error("scanner left halt without reset");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthMax)
    else $error("comment depth beyond limit");

  a_block_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeBlock |-> depth_q != '0)
    else $error("block comment with zero depth");

endmodule

/* sv/mts_fifo.sv */
module mts_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mts_pkg::pair_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output mts_pkg::pair_t head_o,
  output logic           empty_o
);
  import mts_pkg::*;

  pair_t            mem_q [QueueDepth];
  logic [QIdxW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QIdxW'(QueueDepth - 1)) ? '0 : wr_q + QIdxW'(1);
      if (pop_i)  rd_q <= (rd_q == QIdxW'(QueueDepth - 1)) ? '0 : rd_q + QIdxW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + QCntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

/* sv/mts_drain.sv */
module mts_drain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mts_pkg::pair_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  mts_out_if.source      token_o
);
  import mts_pkg::*;

  logic vld_q;
  logic sel_q;
  res_t data_q;
  res_t cur;
  logic load;

  // second result of a pair is loaded once the first has been taken; the pair is popped with it
  assign load  = !empty_i && (!vld_q || token_o.ready);
  assign cur   = sel_q ? head_i.second : head_i.first;
  assign pop_o = load && (!head_i.two || sel_q);

  always_ff @(posedge clk_i) begin
    if (load) data_q <= cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        sel_q <= head_i.two && !sel_q;
      end else if (token_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign token_o.valid         = vld_q;
  assign token_o.token_kind    = data_q.kind;
  assign token_o.error_code    = data_q.err;
  assign token_o.start_line    = data_q.line;
  assign token_o.start_column  = data_q.col;
  assign token_o.lexeme_length = data_q.len;
  assign token_o.last          = data_q.last;

endmodule

/* sv/morse_token_scanner.sv */
// Morse token scanner: turns a stream of source characters into tokens.
// char_i  (sink): one character per transaction with its line and column, or a
//         line-end / program-end marker. valid/ready handshake.
// token_o (source): one token or error per transaction; last marks the final
//         token caused by one character (a character can close a word or a
//         lone '<' and start a token of its own, giving two tokens).
// Throughput: one character per cycle while the result queue has room; one token
// per cycle on the output while token_o.ready is high, so a character that causes two tokens needs two transactions.
// A token reaches token_o from the character that completes it through
// scanner -> result queue -> output register.
// The scanner accepts characters while the 4-entry result queue has room;
// char_i.ready depends only on queue occupancy, not on token_o.ready.
// When the receiver stalls, the output register holds, the queue fills and
// char_i.ready drops until room frees up.
// After an error token the scanner halts: characters are still taken but
// give nothing until reset. Reset (rst_ni low, async) returns the scanner
// to idle, clears comment depth and empties the queue.
module morse_token_scanner #(
  parameter int MAX_COMMENT_DEPTH = mts_pkg::MaxCommentDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mts_in_if.sink    char_i,
  mts_out_if.source token_o
);
  import mts_pkg::*;

  logic  push, full, pop, empty;
  pair_t push_data, head;

  // front: classification and the scan state machine, one character a cycle while the queue has room
  mts_scan #(
    .MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .char_i(char_i),
    .full_i(full),
    .push_o(push),
    .pair_o(push_data)
  );

  // queue of result pairs decouples scanning from the output side
  mts_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  // back: splits pairs and drives the registered output
  mts_drain u_drain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .empty_i(empty),
    .pop_o  (pop),
    .token_o(token_o)
  );

endmodule

/* test/token_checker.sv */
// Watches both channels, predicts the tokens for every accepted character and
// compares each accepted token transaction with the oldest prediction.
module token_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mts_in_if    chars,
  mts_out_if   tokens,
  output int   fail_count,
  output int   awaiting
);
  import mts_pkg::*;

  localparam logic [7:0] ChTab = 8'd9;
  localparam int ReportLimit = 10;

  // pending angle inside comment handling
  localparam logic [1:0] AngleNone  = 2'd0;
  localparam logic [1:0] AngleOpen  = 2'd1;
  localparam logic [1:0] AngleClose = 2'd2;

  typedef enum logic [2:0] {
    ScanIdle, ScanLineComment, ScanBlock, ScanWord, ScanString, ScanEscape, ScanHalted
  } scan_e;

  // reserved words in kind order, starting at KindReservedBase
  string word_text [NumWords] = '{
    "PROGRAM", "END", "ENDL", ".--. .-. .. -. -", "-...-", "-.-", ".-.-.-", ".-..-."
  };

  scan_e          mode;
  int unsigned    depth;
  logic [1:0]     angle;
  logic [NumWords-1:0] live;
  logic [7:0]     tok_len;
  logic [15:0]    tok_line;
  logic [7:0]     tok_col;

  res_t due_q[$];
  res_t step_q[$];
  int   fails = 0;
  int   token_count = 0;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_run(input logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") || c == "_" || c == " " ||
           c == "-" || c == ".";
  endfunction

  task automatic emit(input logic [3:0] kind, input logic [2:0] err,
                      input logic [15:0] line, input logic [7:0] col,
                      input logic [7:0] len);
    res_t r;
    r.kind = kind;
    r.err  = err;
    r.line = line;
    r.col  = col;
    r.len  = len;
    r.last = 1'b0;
    if (step_q.size() < 2) step_q.push_back(r);
  endtask

  task automatic add_word_char(input logic [7:0] c);
    logic [7:0] uc;
    uc = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    for (int w = 0; w < NumWords; w++) begin
      if (live[w] && (tok_len >= word_text[w].len() || word_text[w][tok_len] != uc))
        live[w] = 1'b0;
    end
    if (tok_len < MaxLexeme) tok_len++;
  endtask

  task automatic close_word();
    logic [3:0] kind;
    logic       found;
    kind  = KindIdent;
    found = 1'b0;
    for (int w = 0; w < NumWords; w++) begin
      if (!found && live[w] && tok_len == word_text[w].len()) begin
        kind  = KindReservedBase + 4'(w);
        found = 1'b1;
      end
    end
    emit(kind, ErrNone, tok_line, tok_col, tok_len);
    mode = ScanIdle;
  endtask

  task automatic halt(input logic [2:0] code, input logic [15:0] line, input logic [7:0] col);
    emit(KindError, code, line, col, 8'd0);
    mode  = ScanHalted;
    angle = AngleNone;
  endtask

  task automatic scan_idle(input logic [7:0] c, input logic le, input logic pe,
                           input logic [15:0] line, input logic [7:0] col);
    if (pe) begin
      emit(KindEnd, ErrNone, line, col, 8'd0);
    end else if (!(le || c == "/" || c == ChTab)) begin
      tok_line = line;
      tok_col  = col;
      if (c == "<") begin
        angle = AngleOpen;
      end else if (is_letter(c) || c == "-" || c == ".") begin
        mode    = ScanWord;
        tok_len = 8'd0;
        live    = '1;
        add_word_char(c);
      end else if (c == "\"") begin
        mode    = ScanString;
        tok_len = 8'd0;
      end else if (c == ",") begin
        emit(KindComma, ErrNone, line, col, 8'd1);
      end else if (c == "#") begin
        emit(KindHash, ErrNone, line, col, 8'd1);
      end else begin
        emit(KindUnknown, ErrNone, line, col, 8'd1);
      end
    end
  endtask

  task automatic scan_block(input logic [7:0] c, input logic le, input logic pe,
                            input logic [15:0] line, input logic [7:0] col);
    logic taken;
    taken = 1'b0;
    if (pe) begin
      halt(ErrEndInBlock, line, col);
    end else begin
      if (angle == AngleOpen) begin
        angle = AngleNone;
        if (!le && c == "<") begin
          taken = 1'b1;
          if (depth >= MaxCommentDepth) halt(ErrTooDeep, line, col);
          else depth++;
        end
      end else if (angle == AngleClose) begin
        angle = AngleNone;
        if (!le && c == ">") begin
          taken = 1'b1;
          if (depth > 0) depth--;
          if (depth == 0) mode = ScanIdle;
        end
      end
      if (!taken && !le) begin
        if (c == "<") angle = AngleOpen;
        else if (c == ">") angle = AngleClose;
      end
    end
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic le_in, input logic pe,
                                input logic [15:0] line, input logic [7:0] col);
    logic le;
    logic plain;
    logic handled;
    res_t r;
    le      = le_in && !pe;
    plain   = !le && !pe;
    handled = 1'b0;
    step_q.delete();
    case (mode)
      ScanIdle: begin
        if (angle == AngleOpen) begin
          angle = AngleNone;
          if (plain && c == "~") begin
            mode    = ScanLineComment;
            handled = 1'b1;
          end else if (plain && c == "<") begin
            mode    = ScanBlock;
            depth   = 1;
            handled = 1'b1;
          end else begin
            emit(KindUnknown, ErrNone, tok_line, tok_col, 8'd1);
          end
        end
        if (!handled) scan_idle(c, le, pe, line, col);
      end
      ScanLineComment: begin
        if (le) begin
          mode = ScanIdle;
        end else if (pe) begin
          mode = ScanIdle;
          scan_idle(c, le, pe, line, col);
        end
      end
      ScanBlock: scan_block(c, le, pe, line, col);
      ScanWord: begin
        if (plain && is_run(c)) begin
          add_word_char(c);
        end else begin
          close_word();
          scan_idle(c, le, pe, line, col);
        end
      end
      ScanString: begin
        if (pe) halt(ErrEndInString, tok_line, tok_col);
        else if (le) halt(ErrLineEndInString, tok_line, tok_col);
        else if (c == "\"") begin
          emit(KindString, ErrNone, tok_line, tok_col, tok_len);
          mode = ScanIdle;
        end else if (c == "\\") mode = ScanEscape;
        else if (tok_len < MaxLexeme) tok_len++;
      end
      ScanEscape: begin
        if (pe) begin
          halt(ErrEndInString, tok_line, tok_col);
        end else begin
          if (tok_len < MaxLexeme) tok_len++;
          mode = ScanString;
        end
      end
      default: mode = ScanHalted;
    endcase
    for (int i = 0; i < step_q.size(); i++) begin
      r      = step_q[i];
      r.last = (i == step_q.size() - 1);
      due_q.push_back(r);
    end
  endtask

  task automatic check_token();
    res_t got;
    res_t want;
    got.kind = tokens.token_kind;
    got.err  = tokens.error_code;
    got.line = tokens.start_line;
    got.col  = tokens.start_column;
    got.len  = tokens.lexeme_length;
    got.last = tokens.last;
    if (due_q.size() == 0) begin
      fails++;
      if (fails <= ReportLimit)
        $display("token %0d: none pending, got kind %0d err %0d at %0d:%0d len %0d last %0b",
                 token_count, got.kind, got.err, got.line, got.col, got.len, got.last);
    end else begin
      want = due_q.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= ReportLimit)
          $display("token %0d: expected kind %0d err %0d at %0d:%0d len %0d last %0b,",
                   token_count, want.kind, want.err, want.line, want.col, want.len,
                   want.last, " got kind %0d err %0d at %0d:%0d len %0d last %0b",
                   got.kind, got.err, got.line, got.col, got.len, got.last);
      end
    end
    token_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode     = ScanIdle;
      depth    = 0;
      angle    = AngleNone;
      live     = '1;
      tok_len  = 8'd0;
      tok_line = 16'd0;
      tok_col  = 8'd0;
      due_q.delete();
    end else begin
      if (chars.valid && chars.ready)
        predict_tokens(chars.ch, chars.is_line_end, chars.is_program_end,
                       chars.line_number, chars.line_column);
      if (tokens.valid && tokens.ready) check_token();
    end
    fail_count <= fails;
    awaiting   <= due_q.size();
  end

endmodule

/* test/testbench.sv */
// Top of the scanner bench. Builds character streams, drives them into the
// scanner with random gaps, stalls the token side at random and gives the
// verdict. All prediction and comparison lives in token_checker.
//
// The scanner halts for good on its first error and reset is applied only
// once, so the random stream is built from well-formed pieces that can never
// trip an error. Exactly one error case, picked at random per run, closes the
// stream, followed by a few characters that must produce nothing.
module testbench;
  import mts_pkg::*;

  localparam logic [7:0] ChTab = 8'd9;
  // character budget for the directed part and the random stream together
  localparam int TotalItems  = 550;
  // generous hard limit for the whole run
  localparam int CycleLimit  = 200000;
  // token_o trails the completing character through the queue and output register; leave slack
  localparam int DrainCycles = 20;

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int          awaiting;
  int          cycle_count = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          items_sent = 0;
  logic [15:0] cur_line;
  logic [7:0]  cur_col;

  string word_text [NumWords] = '{
    "PROGRAM", "END", "ENDL", ".--. .-. .. -. -", "-...-", "-.-", ".-.-.-", ".-..-."
  };

  mts_in_if  chars ();
  mts_out_if tokens ();

  morse_token_scanner uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (chars),
    .token_o (tokens)
  );

  token_checker u_token_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .chars      (chars),
    .tokens     (tokens),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // hard stop in case the handshake locks up
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("morse_token_scanner: mismatch");
      $finish;
    end
  end

  // token side: ready drops at random per the current idle rate
  always @(posedge clk_i) begin
    tokens.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One character transaction. valid stays high from one transaction into the
  // next unless the sender decides to idle, so valid sees one update per edge.
  // Position tracking: a line end moves to the next line, a program end jumps
  // to a random place so every position bit gets toggled.
  task automatic put_item(input logic [7:0] c, input logic le, input logic pe);
    set_idle_phase(items_sent * 3 / TotalItems);
    while ($urandom_range(99) < send_idle_pct) begin
      chars.valid <= 1'b0;
      @(posedge clk_i);
    end
    chars.valid          <= 1'b1;
    chars.ch             <= c;
    chars.is_line_end    <= le;
    chars.is_program_end <= pe;
    chars.line_number    <= cur_line;
    chars.line_column    <= cur_col;
    @(posedge clk_i);
    while (!chars.ready) @(posedge clk_i);
    items_sent++;
    if (pe) begin
      cur_line = 16'($urandom);
      cur_col  = 8'($urandom);
    end else if (le) begin
      cur_line++;
      cur_col = 8'd0;
    end else begin
      cur_col++;
    end
  endtask

  task automatic put_char(input logic [7:0] c);
    put_item(c, 1'b0, 1'b0);
  endtask

  // ch is don't-care on markers, so it gets random bits
  task automatic put_line_end();
    put_item(8'($urandom), 1'b1, 1'b0);
  endtask

  // program end wins over a line end flagged in the same transaction
  task automatic put_program_end();
    put_item(8'($urandom), 1'($urandom), 1'b1);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
    logic [7:0] v;
    do v = 8'($urandom); while (v == a || v == b || v == c);
    return v;
  endfunction

  function automatic logic [7:0] letter();
    return 8'($urandom_range(1) ? "A" + $urandom_range(25) : "a" + $urandom_range(25));
  endfunction

  // anything that keeps a word going
  function automatic logic [7:0] run_char();
    logic [7:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = letter();
      4, 5:       v = 8'("0" + $urandom_range(9));
      6:          v = "_";
      7:          v = " ";
      8:          v = "-";
      default:    v = ".";
    endcase
    return v;
  endfunction

  task automatic put_ident(input int n);
    case ($urandom_range(3))
      0:       put_char("-");
      1:       put_char(".");
      default: put_char(letter());
    endcase
    repeat (n - 1) put_char(run_char());
  endtask

  // reserved word with its letters in random case
  task automatic put_reserved();
    int         w;
    logic [7:0] c;
    w = $urandom_range(NumWords - 1);
    for (int i = 0; i < word_text[w].len(); i++) begin
      c = word_text[w][i];
      if (c >= "A" && c <= "Z" && $urandom_range(1)) c = c + 8'd32;
      put_char(c);
    end
  endtask

  // closed string; escapes may swallow a quote, a backslash or a line end
  task automatic put_string(input int n);
    put_char("\"");
    repeat (n) begin
      if ($urandom_range(7) == 0) begin
        put_char("\\");
        case ($urandom_range(3))
          0:       put_line_end();
          1:       put_char("\"");
          default: put_char(8'($urandom));
        endcase
      end else begin
        put_char(any_but("\"", "\\", "\""));
      end
    end
    put_char("\"");
  endtask

  task automatic put_line_comment(input int n);
    put_text("<~");
    repeat (n) put_char(8'($urandom));
    if ($urandom_range(4) == 0) put_program_end();
    else put_line_end();
  endtask

  // Filler inside a block comment. A stray angle is always followed by a
  // letter so it can neither open nor close a level.
  task automatic put_block_filler();
    repeat ($urandom_range(3)) begin
      case ($urandom_range(4))
        0: put_line_end();
        1: begin
          put_char("<");
          put_char(letter());
        end
        2: begin
          put_char(">");
          put_char(letter());
        end
        default: put_char(any_but("<", ">", "<"));
      endcase
    end
  endtask

  // nested block comment, levels deep, never past the depth limit
  task automatic put_block(input int levels);
    repeat (levels) begin
      put_text("<<");
      put_block_filler();
    end
    repeat (levels) begin
      put_block_filler();
      put_text(">>");
    end
  endtask

  // a lone '<' is an unknown token; whatever follows is scanned normally
  task automatic put_lone_angle();
    put_char("<");
    case ($urandom_range(3))
      0:       put_line_end();
      1:       put_program_end();
      default: put_char(any_but("~", "<", "\""));
    endcase
  endtask

  task automatic put_random_unit();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 18) begin
      n = $urandom_range(1, 12);
      put_ident(n);
    end else if (pick < 30) begin
      put_reserved();
    end else if (pick < 46) begin
      case ($urandom_range(2))
        0:       put_char("/");
        1:       put_char(ChTab);
        default: put_line_end();
      endcase
    end else if (pick < 56) begin
      n = $urandom_range(0, 10);
      put_string(n);
    end else if (pick < 62) begin
      put_char($urandom_range(1) ? "," : "#");
    end else if (pick < 70) begin
      // noise: any byte that does not open a string or a comment
      if ($urandom_range(3) == 0) put_item(8'($urandom), 1'b1, 1'b0);
      else put_char(any_but("\"", "<", "\""));
    end else if (pick < 75) begin
      put_line_comment($urandom_range(6));
    end else if (pick < 81) begin
      n = ($urandom_range(9) == 0) ? MaxCommentDepth : $urandom_range(1, 3);
      put_block(n);
    end else if (pick < 87) begin
      put_lone_angle();
    end else if (pick < 93) begin
      put_program_end();
    end else begin
      // word closed by punctuation: two tokens from one character
      put_reserved();
      put_char($urandom_range(1) ? "," : "#");
    end
  endtask

  task automatic set_idle_phase(input int phase);
    case (phase)
      0: begin
        send_idle_pct = 35;
        recv_idle_pct = 71;
      end
      1: begin
        send_idle_pct = 71;
        recv_idle_pct = 35;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    rst_ni               = 1'b0;
    chars.valid          = 1'b0;
    chars.ch             = 8'd0;
    chars.is_line_end    = 1'b0;
    chars.is_program_end = 1'b0;
    chars.line_number    = 16'd0;
    chars.line_column    = 8'd0;
    cur_line             = 16'd1;
    cur_col              = 8'd0;
    set_idle_phase(0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every reserved word with mixed case, a reserved prefix that
    // turns into an identifier, a word ended by a comma, punctuation, byte
    // extremes as unknown tokens
    put_text("PROGRAM/end/EnDl");
    put_char(ChTab);
    put_text(".--. .-. .. -. -/-...-/-.-/.-.-.-/.-..-./ENDX abc_9,#");
    put_char(8'hFF);
    put_char(8'h00);
    // lone '<' before a letter, then one just before the program end
    put_text("<q<");
    put_program_end();
    // string with an escaped line end and an escaped quote, then an empty one
    put_text("\"a\\");
    put_line_end();
    put_text("\\\"\"\"\"");
    // program end closes a line comment
    put_text("<~ note");
    put_program_end();
    put_text("<<x<<y>>z>>");
    put_line_end();
    // identifier length that saturates, then a short string
    put_char("/");
    put_ident(256);
    put_char("/");
    put_string(8);
    put_program_end();

    while (items_sent < TotalItems) put_random_unit();

    // one error to close the run, then the scanner must stay silent
    case ($urandom_range(3))
      0: begin
        put_text("<<x");
        put_program_end();
      end
      1: begin
        put_text("\"ab");
        put_line_end();
      end
      2: begin
        put_text("\"a");
        if ($urandom_range(1)) put_char("\\");
        put_program_end();
      end
      default: repeat (MaxCommentDepth + 1) put_text("<<");
    endcase
    put_text(",#ab\"");
    put_program_end();
    chars.valid <= 1'b0;

    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && awaiting == 0) begin
      $display("morse_token_scanner: match");
    end else begin
      $display("morse_token_scanner: mismatch");
    end
    $finish;
  end

endmodule
